// ===== hdl/mmrp_pkg.sv =====
package mmrp_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 37;
    localparam int POS_W       = 6;
    localparam int DATA_FIRST  = 3;
    localparam int CRC_LO_POS  = FRAME_BYTES - 2;
    localparam int CRC_HI_POS  = FRAME_BYTES - 1;

    // Kept meter registers: 0, 1, 2, 4 and 7
    localparam int WORD_W     = 32;
    localparam int KEPT_COUNT = 5;
    localparam int SLOT_W     = 3;
    localparam int REG_NUM_W  = 3;

    localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(KEPT_COUNT);

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [15:0]       crc_t;

    // One byte through the reflected CRC, bit by bit
    function automatic crc_t crc16_byte(input crc_t crc, input logic [7:0] b);
        crc_t c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Slot for a meter register number, SLOT_NONE if it is not kept
    function automatic logic [SLOT_W-1:0] slot_of(input logic [REG_NUM_W-1:0] r);
        logic [SLOT_W-1:0] s;
        unique case (r)
            3'd0:    s = SLOT_W'(0);
            3'd1:    s = SLOT_W'(1);
            3'd2:    s = SLOT_W'(2);
            3'd4:    s = SLOT_W'(3);
            3'd7:    s = SLOT_W'(4);
            default: s = SLOT_NONE;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/modbus_meter_reply_parser.sv =====
// Checks a 37-byte Modbus RTU meter reply, one byte per item on the slave side
// (s_tuser high marks byte 0; after reset the first byte counts as byte 0 anyway).
// CRC-16/MODBUS runs over bytes 0..34 and is compared with the little-endian CRC
// in bytes 35..36; the big-endian 32-bit registers 0, 1, 2, 4 and 7 from bytes
// 3..34 are kept. After byte 36 one item leaves on the master side: m_tuser is the
// CRC pass flag and m_tdata the five counts, all zero on a CRC error. A start mark
// mid-frame drops the partial frame; bytes after a complete frame without a start
// mark are ignored. The block takes one byte every clock; after its last byte is accepted a
// result passes through the input register and then the result register, with the
// CRC compare on the held byte feeding the result register. Input stalls
// only while the final byte of a frame waits behind an untaken result.
module modbus_meter_reply_parser
    import mmrp_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    input  logic                         s_tuser,   // [0] start_of_frame
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [KEPT_COUNT*WORD_W-1:0] m_tdata,   // voltage, current, power,
                                                    // power_factor, frequency
    output logic                         m_tuser    // [0] frame_ok
);

    // Input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_sof_reg;

    // Frame state
    pos_t   pos_reg, pos_next;
    crc_t   crc_reg, crc_next;
    word_t  word_reg, word_next;
    logic [7:0] crc_lo_reg, crc_lo_next;
    word_t  kept_reg [KEPT_COUNT];
    word_t  kept_next [KEPT_COUNT];

    // Result register
    logic                         m_vld_reg, m_vld_next;
    logic                         ok_reg, ok_next;
    logic [KEPT_COUNT*WORD_W-1:0] m_data_reg, m_data_next;

    // Working signals
    pos_t              pos_eff, off;
    crc_t              crc_eff, rx_crc;
    word_t             word_eff, word_new;
    logic              active, emit, in_go, in_data, ok;
    logic [SLOT_W-1:0] slot;

    // Frame decode for the held byte
    always_comb begin
        pos_eff  = in_sof_reg ? '0 : pos_reg;
        crc_eff  = in_sof_reg ? CRC_INIT : crc_reg;
        word_eff = in_sof_reg ? '0 : word_reg;
        active   = pos_eff < POS_W'(FRAME_BYTES);
        emit     = active && (pos_eff == POS_W'(CRC_HI_POS));
        in_go    = in_vld_reg && (!emit || !m_vld_reg || m_tready);
        off      = pos_eff - POS_W'(DATA_FIRST);
        word_new = {word_eff[WORD_W-9:0], in_byte_reg};
        in_data  = active && (pos_eff >= POS_W'(DATA_FIRST))
                   && (pos_eff < POS_W'(CRC_LO_POS));
        slot     = slot_of(off[4:2]);
        rx_crc   = {in_byte_reg, crc_lo_reg};
        ok       = rx_crc == crc_eff;
    end

    assign s_tready    = !in_vld_reg || in_go;
    assign in_vld_next = s_tready ? s_tvalid : in_vld_reg;

    // Next frame state
    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        word_next   = word_reg;
        crc_lo_next = crc_lo_reg;
        kept_next   = kept_reg;
        if (in_go) begin
            pos_next  = pos_eff;
            crc_next  = crc_eff;
            word_next = word_eff;
            if (active) begin
                pos_next = pos_eff + POS_W'(1);
                if (pos_eff < POS_W'(CRC_LO_POS)) begin
                    crc_next = crc16_byte(crc_eff, in_byte_reg);
                end
                if (in_data) begin
                    word_next = word_new;
                    if (off[1:0] == 2'b11 && slot != SLOT_NONE) begin
                        kept_next[slot] = word_new;
                    end
                end
                if (pos_eff == POS_W'(CRC_LO_POS)) begin
                    crc_lo_next = in_byte_reg;
                end
            end
        end
    end

    // Next result
    always_comb begin
        m_vld_next  = m_vld_reg && !m_tready;
        ok_next     = ok_reg;
        m_data_next = m_data_reg;
        if (in_go && emit) begin
            m_vld_next = 1'b1;
            ok_next    = ok;
            for (int i = 0; i < KEPT_COUNT; i++) begin
                m_data_next[i*WORD_W +: WORD_W] = ok ? kept_reg[i] : '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            pos_reg    <= '0;
            crc_reg    <= CRC_INIT;
            word_reg   <= '0;
            crc_lo_reg <= '0;
        end else begin
            in_vld_reg <= in_vld_next;
            m_vld_reg  <= m_vld_next;
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            word_reg   <= word_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
            in_sof_reg  <= s_tuser;
        end
        kept_reg   <= kept_next;
        ok_reg     <= ok_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = ok_reg;

endmodule

// ===== hdl/mmrp_checker.sv =====
module mmrp_checker
    import mmrp_pkg::*;
(
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [7:0]                   s_tdata,
    input logic                         s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [KEPT_COUNT*WORD_W-1:0] m_tdata,
    input logic                         m_tuser
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A failed CRC carries no counts
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("counts not cleared on CRC error");

    // A fresh result follows an accepted input byte
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding byte");

    // Nothing pending straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind modbus_meter_reply_parser mmrp_checker u_mmrp_checker (.*);
